// ----- sv/lppd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg: shared types and constants of the packet deframer
// Request codes and the request record passed from the front to the back.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam logic [2:0]  HDR_TYPE_BYTES    = 3'd2;
    localparam logic [2:0]  HDR_LAST_IDX      = 3'd5;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        OP_DATA,
        OP_DATA_LAST,
        OP_EMPTY,
        OP_OVERSIZE
    } lppd_op_t;

    typedef struct packed {
        lppd_op_t    op;
        logic [15:0] ptype;
        logic [7:0]  pbyte;
    } lppd_req_t;

endpackage

// ----- sv/lppd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_front: header parser and byte classifier
// Takes one byte per cycle while the queue is not full, tracks header and
// payload phase, and issues a request for every byte that gives a result.
// ----------------------------------------------------------------------------
module lppd_front
    import lppd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        push_valid,
    output lppd_req_t   push_req,
    input  logic        q_full
);

    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic        in_payload_reg, in_payload_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] max_payload_reg;
    logic        accept;
    logic        has_result;
    lppd_op_t    op;
    logic [31:0] length_shifted;

    assign s_ready        = !q_full;
    assign accept         = s_valid && s_ready;
    assign length_shifted = {length_reg[23:0], s_data_byte};

    always_comb begin
        hdr_idx_next    = hdr_idx_reg;
        in_payload_next = in_payload_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        remain_next     = remain_reg;
        has_result      = 1'b0;
        op              = OP_DATA;
        if (in_payload_reg) begin
            remain_next = remain_reg - 32'd1;
            has_result  = 1'b1;
            if (remain_reg == 32'd1) begin
                op              = OP_DATA_LAST;
                in_payload_next = 1'b0;
            end
        end else if (hdr_idx_reg < HDR_TYPE_BYTES) begin
            type_next    = {type_reg[7:0], s_data_byte};
            hdr_idx_next = hdr_idx_reg + 3'd1;
        end else begin
            length_next = length_shifted;
            if (hdr_idx_reg < HDR_LAST_IDX) begin
                hdr_idx_next = hdr_idx_reg + 3'd1;
            end else begin
                hdr_idx_next = 3'd0;
                if (length_shifted > max_payload_reg) begin
                    has_result = 1'b1;
                    op         = OP_OVERSIZE;
                end else if (length_shifted == 32'd0) begin
                    has_result = 1'b1;
                    op         = OP_EMPTY;
                end else begin
                    remain_next     = length_shifted;
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    assign push_valid     = accept && has_result;
    assign push_req.op    = op;
    assign push_req.ptype = type_reg;
    // payload byte only travels with data requests
    assign push_req.pbyte = in_payload_reg ? s_data_byte : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_idx_reg     <= 3'd0;
            in_payload_reg  <= 1'b0;
            type_reg        <= 16'd0;
            length_reg      <= 32'd0;
            remain_reg      <= 32'd0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
            if (accept) begin
                hdr_idx_reg    <= hdr_idx_next;
                in_payload_reg <= in_payload_next;
                type_reg       <= type_next;
                length_reg     <= length_next;
                remain_reg     <= remain_next;
            end
        end
    end

endmodule

// ----- sv/lppd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_queue: short request queue between front and back
// Circular buffer with a fill count; push and pop may occur together.
// ----------------------------------------------------------------------------
module lppd_queue
    import lppd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  lppd_req_t push_req,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop_ready,
    output lppd_req_t pop_req
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lppd_req_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_req   = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ----- sv/lppd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_back: result formatter with output register
// Decodes each queued request into result fields and holds them until taken.
// ----------------------------------------------------------------------------
module lppd_back
    import lppd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  lppd_req_t   pop_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_packet_type,
    output logic [7:0]  m_payload_byte,
    output logic        m_has_data,
    output logic        m_last_of_packet,
    output logic        m_oversize_error
);

    logic        valid_reg;
    logic [15:0] type_reg;
    logic [7:0]  byte_reg;
    logic        has_reg, last_reg, err_reg;
    logic        has_next, last_next, err_next;
    logic        load;

    // refill the output register when it is empty or being drained
    assign pop_ready = !valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        has_next  = 1'b0;
        last_next = 1'b0;
        err_next  = 1'b0;
        case (pop_req.op)
            OP_DATA: begin
                has_next = 1'b1;
            end
            OP_DATA_LAST: begin
                has_next  = 1'b1;
                last_next = 1'b1;
            end
            OP_EMPTY: begin
                last_next = 1'b1;
            end
            OP_OVERSIZE: begin
                err_next = 1'b1;
            end
            default: begin
                has_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            type_reg <= pop_req.ptype;
            byte_reg <= pop_req.pbyte;
            has_reg  <= has_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_packet_type    = type_reg;
    assign m_payload_byte   = byte_reg;
    assign m_has_data       = has_reg;
    assign m_last_of_packet = last_reg;
    assign m_oversize_error = err_reg;

endmodule

// ----- sv/length_prefixed_packet_deframer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core: type-length-value byte deframer
// Splits a byte stream into packets with a 2-byte type and 4-byte length
// header, big-endian, and emits one result per payload byte.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while s_ready is high and gives
// at most one result per byte; each passes the queue and then the output
// register on its way to the m_ channel. The front parser writes each
// request into a queue of QUEUE_DEPTH entries, and s_ready falls only when
// that queue is full, so a stalled output holds QUEUE_DEPTH results plus one
// in the output register before input stops. Header bytes give no result
// except the sixth, which gives an error result when the length exceeds
// max_payload or a last-flagged empty result when the length is zero, and
// max_payload is sampled there, so an earlier write applies to that header.
module length_prefixed_packet_deframer_core
    import lppd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_packet_type,
    output logic [7:0]  m_payload_byte,
    output logic        m_has_data,
    output logic        m_last_of_packet,
    output logic        m_oversize_error
);

    logic      push_valid;
    lppd_req_t push_req;
    logic      q_full;
    logic      pop_valid;
    logic      pop_ready;
    lppd_req_t pop_req;

    lppd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_req    (push_req),
        .q_full      (q_full)
    );

    lppd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_req   (push_req),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    lppd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_req          (pop_req),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_type    (m_packet_type),
        .m_payload_byte   (m_payload_byte),
        .m_has_data       (m_has_data),
        .m_last_of_packet (m_last_of_packet),
        .m_oversize_error (m_oversize_error)
    );

endmodule

// ----- sv/lppd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_checker: port-level checks for the packet deframer
// Checks stall hold, idle after reset and consistent flag combinations.
// ----------------------------------------------------------------------------
module lppd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_packet_type,
    input logic [7:0]  m_payload_byte,
    input logic        m_has_data,
    input logic        m_last_of_packet,
    input logic        m_oversize_error
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_type)
            && $stable(m_payload_byte) && $stable(m_has_data)
            && $stable(m_last_of_packet) && $stable(m_oversize_error))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_data_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_data |-> !m_oversize_error)
        else $error("data result flagged as oversize");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_oversize_error |-> !m_last_of_packet && !m_has_data)
        else $error("oversize result carries data or last flag");

    a_nodata_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> (m_payload_byte == 8'd0)
            && (m_last_of_packet != m_oversize_error))
        else $error("dataless result is neither empty packet nor error");

endmodule

bind length_prefixed_packet_deframer_core lppd_checker u_lppd_checker (.*);

// ----- test/lppd_deframe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_deframe_checker: deframing predictor and result comparison
// Watches the byte channel and the configuration port, works out the request
// each byte should raise, and compares each accepted result against the
// oldest one still due.
// ----------------------------------------------------------------------------
module lppd_deframe_checker
    import lppd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_packet_type,
    input  logic [7:0]  m_payload_byte,
    input  logic        m_has_data,
    input  logic        m_last_of_packet,
    input  logic        m_oversize_error,
    output int          mismatches,
    output int          outstanding
);

    // Own copy of the parser state
    logic [2:0]  hdr_pos;
    logic        in_payload;
    logic [15:0] type_sr;
    logic [31:0] len_sr;
    logic [31:0] bytes_left;
    logic [31:0] payload_limit;

    lppd_req_t deframed_q[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: deframer mismatch on %s: got %0h, want %0h",
                 $time, what, got, want);
        mismatches++;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        lppd_req_t req;
        req.ptype = type_sr;
        req.pbyte = 8'h00;
        req.op    = OP_DATA;
        if (in_payload) begin
            bytes_left = bytes_left - 32'd1;
            req.pbyte  = b;
            if (bytes_left == 32'd0) begin
                in_payload = 1'b0;
                req.op     = OP_DATA_LAST;
            end
            deframed_q.push_back(req);
        end else if (hdr_pos < HDR_TYPE_BYTES) begin
            type_sr = {type_sr[7:0], b};
            hdr_pos = hdr_pos + 3'd1;
        end else begin
            len_sr = {len_sr[23:0], b};
            if (hdr_pos < HDR_LAST_IDX) begin
                hdr_pos = hdr_pos + 3'd1;
            end else begin
                // header complete: the limit is taken as it stands now
                hdr_pos = 3'd0;
                if (len_sr > payload_limit) begin
                    req.op = OP_OVERSIZE;
                    deframed_q.push_back(req);
                end else if (len_sr == 32'd0) begin
                    req.op = OP_EMPTY;
                    deframed_q.push_back(req);
                end else begin
                    bytes_left = len_sr;
                    in_payload = 1'b1;
                end
            end
        end
    endtask

    task automatic check_result();
        lppd_req_t want;
        logic      want_data;
        logic      want_last;
        logic      want_err;
        if (deframed_q.size() == 0) begin
            report_mismatch("unexpected result", 32'(m_packet_type), 32'h0);
            return;
        end
        want      = deframed_q.pop_front();
        want_data = (want.op == OP_DATA) || (want.op == OP_DATA_LAST);
        want_last = (want.op == OP_DATA_LAST) || (want.op == OP_EMPTY);
        want_err  = (want.op == OP_OVERSIZE);
        if (m_packet_type !== want.ptype)
            report_mismatch("packet_type", 32'(m_packet_type), 32'(want.ptype));
        if (m_payload_byte !== want.pbyte)
            report_mismatch("payload_byte", 32'(m_payload_byte), 32'(want.pbyte));
        if (m_has_data !== want_data)
            report_mismatch("has_data", 32'(m_has_data), 32'(want_data));
        if (m_last_of_packet !== want_last)
            report_mismatch("last_of_packet", 32'(m_last_of_packet), 32'(want_last));
        if (m_oversize_error !== want_err)
            report_mismatch("oversize_error", 32'(m_oversize_error), 32'(want_err));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos       = 3'd0;
            in_payload    = 1'b0;
            type_sr       = 16'h0;
            len_sr        = 32'h0;
            bytes_left    = 32'h0;
            payload_limit = MAX_PAYLOAD_RESET;
            deframed_q.delete();
        end else begin
            if (cfg_wr_en)
                payload_limit = cfg_wr_data;
            if (s_valid && s_ready)
                deframe_byte(s_data_byte);
            if (m_valid && m_ready)
                check_result();
        end
        outstanding = deframed_q.size();
    end

endmodule

// ----- test/length_prefixed_packet_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core_tb: regression of the packet deframer
// Drives directed headers (empty, oversize, length at the limit, limit changed
// mid-header and mid-payload), then random packets under a range of payload
// limits with bursty stalls on both channels; the checker does the comparing.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core_tb
    import lppd_pkg::*;
;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_packet_type;
    logic [7:0]  m_payload_byte;
    logic        m_has_data;
    logic        m_last_of_packet;
    logic        m_oversize_error;

    int          mismatches;
    int          outstanding;

    bit          idle_en     = 1'b1;
    int unsigned stall_left  = 0;
    int unsigned bytes_sent  = 0;
    logic [31:0] cur_limit   = MAX_PAYLOAD_RESET;

    length_prefixed_packet_deframer_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_type    (m_packet_type),
        .m_payload_byte   (m_payload_byte),
        .m_has_data       (m_has_data),
        .m_last_of_packet (m_last_of_packet),
        .m_oversize_error (m_oversize_error)
    );

    lppd_deframe_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_type    (m_packet_type),
        .m_payload_byte   (m_payload_byte),
        .m_has_data       (m_has_data),
        .m_last_of_packet (m_last_of_packet),
        .m_oversize_error (m_oversize_error),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("length_prefixed_packet_deframer_core regression: fail");
        $finish;
    end

    // Result side: stall in random bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        // let the checker take in the last accepted byte first
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_payload_limit(input logic [31:0] v);
        wait_drained();
        // let a header byte still in the pipe settle
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_limit = v;
    endtask

    task automatic send_packet(input logic [15:0] ptype, input logic [31:0] plen);
        push_byte(ptype[15:8]);
        push_byte(ptype[7:0]);
        push_byte(plen[31:24]);
        push_byte(plen[23:16]);
        push_byte(plen[15:8]);
        push_byte(plen[7:0]);
        if (plen <= cur_limit)
            for (int i = 0; i < plen; i++)
                push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic random_packet();
        logic [31:0] plen;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            plen = $urandom_range(0, 12);
        end else if (pick == 6) begin
            plen = $urandom_range(13, 48);
        end else if (pick == 7 && cur_limit < 48) begin
            // on the limit or one past it
            plen = cur_limit + $urandom_range(0, 1);
        end else begin
            // raw header noise; keep any accepted payload short
            plen = $urandom();
            if (plen <= cur_limit && plen > 48)
                plen = plen % 49;
        end
        send_packet(16'($urandom_range(0, 65535)), plen);
    endtask

    task automatic run_stretch(input int unsigned n_bytes, input bit idle, input bit pause);
        int unsigned stop_at;
        bit          paused;
        stop_at = bytes_sent + n_bytes;
        paused  = 1'b0;
        idle_en = idle;
        while (bytes_sent < stop_at) begin
            random_packet();
            if (pause && !paused && bytes_sent >= stop_at - n_bytes / 2) begin
                // hold the sender until every request has come out
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty packet and widest oversize length at the reset limit
        send_packet(16'h0000, 32'h0000_0000);
        send_packet(16'h8001, 32'hFFFF_FFFF);
        // Length equal to the limit is accepted
        set_payload_limit(32'd2);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'hFF);
        push_byte(8'h00);
        // Limit raised part-way through a header applies to that header
        push_byte(8'hC3);
        push_byte(8'h3C);
        push_byte(8'h00);
        set_payload_limit(32'hFFFF_FFFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'h80);
        // Limit dropped mid-payload leaves the current packet alone
        set_payload_limit(32'h0000_0000);
        push_byte(8'h7F);
        push_byte(8'h01);

        // Random packets across a range of limits
        run_stretch(240, 1'b1, 1'b0);
        set_payload_limit(32'hFFFF_FFFF);
        run_stretch(240, 1'b0, 1'b0);
        set_payload_limit(32'd1);
        run_stretch(240, 1'b1, 1'b1);
        set_payload_limit($urandom_range(4, 40));
        run_stretch(240, 1'b1, 1'b0);
        set_payload_limit(32'hFFFF_FFFE);
        send_packet(16'($urandom_range(0, 65535)), 32'hFFFF_FFFF);
        run_stretch(240, 1'b1, 1'b0);
        set_payload_limit($urandom());
        run_stretch(240, 1'b1, 1'b0);
        set_payload_limit(MAX_PAYLOAD_RESET);
        run_stretch(210, 1'b0, 1'b0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("length_prefixed_packet_deframer_core regression: pass");
        else
            $display("length_prefixed_packet_deframer_core regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lppd_pkg.sv
sv/lppd_front.sv
sv/lppd_queue.sv
sv/lppd_back.sv
sv/length_prefixed_packet_deframer_core.sv
sv/lppd_checker.sv
test/lppd_deframe_checker.sv
test/length_prefixed_packet_deframer_core_tb.sv
